### hdl/t2fp_pkg.sv
// Package for the track 2 field parser: item types, phase codes and character constants.
package t2fp_pkg;

  // ASCII characters with a special meaning on track 2
  localparam logic [7:0] CH_END   = 8'h3F;  // '?'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_APOS  = 8'h27;  // apostrophe
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Field lengths
  localparam logic [4:0] ACCT_MAX = 5'd19;
  localparam logic [2:0] EXP_LEN  = 3'd4;
  localparam logic [2:0] SVC_LEN  = 3'd3;

  // Output queue depth and pointer widths
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    PH_ACCT  = 2'd0,
    PH_EXP   = 2'd1,
    PH_SVC   = 2'd2,
    PH_TRAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACCT = 2'd0,
    KIND_EXP  = 2'd1,
    KIND_SVC  = 2'd2,
    KIND_STAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_ACCT_LONG = 2'd2,
    ST_SHORT     = 2'd3
  } status_e;

  // One result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    status_e    status;
    logic [4:0] acct_len;
    logic       last;
  } item_t;

  // Results of one input word, character item first
  typedef struct packed {
    logic  char_vld;
    item_t char_item;
    logic  stat_vld;
    item_t stat_item;
  } push_t;

endpackage

### hdl/t2fp_core.sv
// Parse state of one track and the results of one input word.
module t2fp_core import t2fp_pkg::*; #(
  parameter int MaxTrackChars = 37
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] symbol_i,
  input  logic       final_char_i,
  output push_t      push_o
);

  localparam int CntW = $clog2(MaxTrackChars + 1);

  logic [CntW-1:0] char_count_q, char_count_d;
  logic            first_seen_q, first_seen_d;
  logic            ended_q, ended_d;
  phase_e          phase_q, phase_d;
  logic [2:0]      phase_count_q, phase_count_d;
  logic            bad_char_q, bad_char_d;
  logic            overflow_q, overflow_d;
  logic [4:0]      acct_len_q, acct_len_d;

  logic [7:0] sym;
  logic       keep;
  logic [2:0] pc_inc;
  push_t      push;

  // Map, filter and route one character; build the status word on the last one
  always_comb begin
    char_count_d  = char_count_q;
    first_seen_d  = first_seen_q;
    ended_d       = ended_q;
    phase_d       = phase_q;
    phase_count_d = phase_count_q;
    bad_char_d    = bad_char_q;
    overflow_d    = overflow_q;
    acct_len_d    = acct_len_q;
    sym           = symbol_i;
    keep          = 1'b0;
    pc_inc        = phase_count_q + 3'd1;
    push          = '0;

    if (!ended_q) begin
      if (symbol_i == CH_END) begin
        ended_d      = 1'b1;
        first_seen_d = 1'b1;
      end else begin
        if (symbol_i == CH_APOS || symbol_i == CH_GT) begin
          sym = CH_EQ;
        end
        if (!first_seen_q) begin
          first_seen_d = 1'b1;
          keep         = (sym != CH_COLON);
        end else begin
          keep = 1'b1;
        end
        if (keep && char_count_q >= CntW'(MaxTrackChars)) begin
          ended_d = 1'b1;
          keep    = 1'b0;
        end
      end
    end

    if (keep) begin
      char_count_d = char_count_q + CntW'(1);
      if (!((sym >= CH_ZERO && sym <= CH_NINE) || sym == CH_EQ)) begin
        bad_char_d = 1'b1;
      end
      unique case (phase_q)
        PH_ACCT: begin
          if (sym == CH_EQ || sym == CH_D) begin
            phase_d       = PH_EXP;
            phase_count_d = 3'd0;
          end else if (acct_len_q < ACCT_MAX) begin
            push.char_vld        = 1'b1;
            push.char_item.kind  = KIND_ACCT;
            push.char_item.value = sym;
            acct_len_d           = acct_len_q + 5'd1;
          end else begin
            overflow_d = 1'b1;
          end
        end
        PH_EXP: begin
          push.char_vld        = 1'b1;
          push.char_item.kind  = KIND_EXP;
          push.char_item.value = sym;
          phase_count_d        = pc_inc;
          if (pc_inc >= EXP_LEN) begin
            phase_d       = PH_SVC;
            phase_count_d = 3'd0;
          end
        end
        PH_SVC: begin
          push.char_vld        = 1'b1;
          push.char_item.kind  = KIND_SVC;
          push.char_item.value = sym;
          phase_count_d        = pc_inc;
          if (pc_inc >= SVC_LEN) begin
            phase_d       = PH_TRAIL;
            phase_count_d = 3'd0;
          end
        end
        PH_TRAIL: begin
          // checked above, not emitted
        end
        default: begin
        end
      endcase
    end

    if (final_char_i) begin
      push.stat_vld           = 1'b1;
      push.stat_item.kind     = KIND_STAT;
      push.stat_item.acct_len = acct_len_d;
      push.stat_item.last     = 1'b1;
      priority if (bad_char_d) begin
        push.stat_item.status = ST_BAD_CHAR;
      end else if (overflow_d) begin
        push.stat_item.status = ST_ACCT_LONG;
      end else if (phase_d != PH_TRAIL) begin
        push.stat_item.status = ST_SHORT;
      end else begin
        push.stat_item.status = ST_OK;
      end
      // start the next track from scratch
      char_count_d  = '0;
      first_seen_d  = 1'b0;
      ended_d       = 1'b0;
      phase_d       = PH_ACCT;
      phase_count_d = 3'd0;
      bad_char_d    = 1'b0;
      overflow_d    = 1'b0;
      acct_len_d    = 5'd0;
    end
  end

  // Gate the results with the consume strobe
  always_comb begin
    push_o          = push;
    push_o.char_vld = push.char_vld & fire_i;
    push_o.stat_vld = push.stat_vld & fire_i;
  end

  // Advance the track state on each consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q  <= '0;
      first_seen_q  <= 1'b0;
      ended_q       <= 1'b0;
      phase_q       <= PH_ACCT;
      phase_count_q <= 3'd0;
      bad_char_q    <= 1'b0;
      overflow_q    <= 1'b0;
      acct_len_q    <= 5'd0;
    end else if (fire_i) begin
      char_count_q  <= char_count_d;
      first_seen_q  <= first_seen_d;
      ended_q       <= ended_d;
      phase_q       <= phase_d;
      phase_count_q <= phase_count_d;
      bad_char_q    <= bad_char_d;
      overflow_q    <= overflow_d;
      acct_len_q    <= acct_len_d;
    end
  end

  // The account length never passes the field maximum
  a_acct_len_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acct_len_q <= ACCT_MAX)
    else $error("account length above maximum");

  // A status word comes exactly with a consumed last character
  a_stat_on_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.stat_vld == (fire_i && final_char_i))
    else $error("status word without last character");

  // The last character returns the parser to a fresh track
  a_reset_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && final_char_i) |=> (phase_q == PH_ACCT && char_count_q == '0
                                  && !first_seen_q && !ended_q))
    else $error("state not cleared after last character");

endmodule

### hdl/t2fp_outq.sv
// Four-entry result queue that takes up to two words a cycle and gives one unless the output stalls.
module t2fp_outq import t2fp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output item_t head_o
);

  item_t             ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QPTR_W-1:0] stat_idx;
  logic              pop;
  logic [QCNT_W-1:0] n_push;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = ent_q[rd_q];
  // room for two words regardless of a pop this cycle
  assign space_o     = (cnt_q <= QCNT_W'(QDEPTH - 2));

  assign n_push   = QCNT_W'(push_i.char_vld) + QCNT_W'(push_i.stat_vld);
  assign stat_idx = wr_q + QPTR_W'(push_i.char_vld);
  assign wr_d     = wr_q + QPTR_W'(n_push);
  assign rd_d     = rd_q + QPTR_W'(pop);
  assign cnt_d    = cnt_q + n_push - QCNT_W'(pop);

  // Write the entries
  always_ff @(posedge clk_i) begin
    if (push_i.char_vld) begin
      ent_q[wr_q] <= push_i.char_item;
    end
    if (push_i.stat_vld) begin
      ent_q[stat_idx] <= push_i.stat_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Never push more than the free entries
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + n_push) <= QCNT_W'(QDEPTH) + QCNT_W'(pop))
    else $error("result queue overflow");

endmodule

### hdl/track2_field_parser.sv
// Top level of the track 2 field parser: input register, parser and result queue.
// An accepted word is held in the input register, then parsed into the result queue.
// Throughput: one input word per cycle unless the input stalls; a last character that also
// emits a character gives two results, which the four-entry result queue takes at once and
// gives out one per cycle unless the output stalls.
// Input stalls only when a word is held and the result queue has fewer than two free entries.
// Reset (rst_ni low, asynchronous) clears the track state, the queue and the input valid flag.
module track2_field_parser import t2fp_pkg::*; #(
  parameter int MAX_TRACK_CHARS = 37
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic [1:0] status_o,
  output logic [4:0] account_length_o,
  output logic       last_result_o
);

  logic       in_vld_q;
  logic [7:0] sym_q;
  logic       fin_q;
  logic       space;
  logic       fire;
  push_t      push;
  item_t      head;

  assign fire       = in_vld_q && space;
  assign in_stall_o = in_vld_q && !space;

  // Hold the input word until the parser consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sym_q <= symbol_i;
      fin_q <= final_char_i;
    end
  end

  t2fp_core #(
    .MaxTrackChars(MAX_TRACK_CHARS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .symbol_i    (sym_q),
    .final_char_i(fin_q),
    .push_o      (push)
  );

  t2fp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign kind_o           = head.kind;
  assign value_o          = head.value;
  assign status_o         = head.status;
  assign account_length_o = head.acct_len;
  assign last_result_o    = head.last;

  // A stall is only raised for a waiting word
  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with no word held");

endmodule

### dv/track2_field_parser_test.sv
// Testbench for the track 2 field parser: directed and random tracks checked against a predictor.
module track2_field_parser_test;
  import t2fp_pkg::*;

  localparam int TRACK_LIMIT = 37;
  localparam int DIR_N       = 21;
  localparam int RAND_WORDS  = 500;

  // One row of the directed plan; the status word is typed in where marked
  typedef struct {
    logic [7:0] sym;
    logic       fin;
    logic       typed;
    status_e    st;
    logic [4:0] alen;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] symbol_i = 8'h00;
  logic       final_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] value_o;
  logic [1:0] status_o;
  logic [4:0] account_length_o;
  logic       last_result_o;

  // Predicted track state
  logic [5:0] trk_chars;
  logic       trk_started;
  logic       trk_done;
  phase_e     trk_phase;
  logic [4:0] trk_phase_cnt;
  logic       trk_bad;
  logic       trk_overflow;
  logic [4:0] trk_acct;

  item_t      due_items[$];
  logic [7:0] trk_bytes[$];
  plan_row_t  dir_plan[DIR_N];
  int         err_cnt = 0;
  int         sent_words = 0;
  logic       quiet = 1'b0;

  track2_field_parser #(.MAX_TRACK_CHARS(TRACK_LIMIT)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .symbol_i         (symbol_i),
    .final_char_i     (final_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .value_o          (value_o),
    .status_o         (status_o),
    .account_length_o (account_length_o),
    .last_result_o    (last_result_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic item_t make_item(kind_e k, logic [7:0] v, status_e s, logic [4:0] a,
                                      logic l);
    item_t it;
    it.kind     = k;
    it.value    = v;
    it.status   = s;
    it.acct_len = a;
    it.last     = l;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    logic [7:0] b;
    b = $urandom_range(0, 9);
    return CH_ZERO + b;
  endfunction

  // Mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic clear_track();
    trk_chars     = '0;
    trk_started   = 1'b0;
    trk_done      = 1'b0;
    trk_phase     = PH_ACCT;
    trk_phase_cnt = '0;
    trk_bad       = 1'b0;
    trk_overflow  = 1'b0;
    trk_acct      = '0;
  endtask

  // Advance the track state by one accepted word and queue the words it yields
  task automatic parse_symbol(input logic [7:0] sym, input logic fin, input logic typed,
                              input status_e typed_st, input logic [4:0] typed_alen);
    logic [7:0] ch;
    logic       keep;
    status_e    st;
    ch   = sym;
    keep = 1'b0;
    if (!trk_done) begin
      if (ch == CH_END) begin
        trk_done    = 1'b1;
        trk_started = 1'b1;
      end else begin
        if (ch == CH_APOS || ch == CH_GT) ch = CH_EQ;
        if (!trk_started) begin
          trk_started = 1'b1;
          keep        = (ch != CH_COLON);
        end else begin
          keep = 1'b1;
        end
        if (keep && trk_chars >= TRACK_LIMIT) begin
          trk_done = 1'b1;
          keep     = 1'b0;
        end
      end
    end
    if (keep) begin
      trk_chars = trk_chars + 6'd1;
      if (!((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_EQ)) trk_bad = 1'b1;
      case (trk_phase)
        PH_ACCT: begin
          if (ch == CH_EQ || ch == CH_D) begin
            trk_phase     = PH_EXP;
            trk_phase_cnt = '0;
          end else if (trk_acct < ACCT_MAX) begin
            due_items.push_back(make_item(KIND_ACCT, ch, ST_OK, 5'd0, 1'b0));
            trk_acct = trk_acct + 5'd1;
          end else begin
            trk_overflow = 1'b1;
          end
        end
        PH_EXP: begin
          due_items.push_back(make_item(KIND_EXP, ch, ST_OK, 5'd0, 1'b0));
          trk_phase_cnt = trk_phase_cnt + 5'd1;
          if (trk_phase_cnt >= EXP_LEN) begin
            trk_phase     = PH_SVC;
            trk_phase_cnt = '0;
          end
        end
        PH_SVC: begin
          due_items.push_back(make_item(KIND_SVC, ch, ST_OK, 5'd0, 1'b0));
          trk_phase_cnt = trk_phase_cnt + 5'd1;
          if (trk_phase_cnt >= SVC_LEN) begin
            trk_phase     = PH_TRAIL;
            trk_phase_cnt = '0;
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      if (trk_bad) st = ST_BAD_CHAR;
      else if (trk_overflow) st = ST_ACCT_LONG;
      else if (trk_phase != PH_TRAIL) st = ST_SHORT;
      else st = ST_OK;
      if (typed) due_items.push_back(make_item(KIND_STAT, 8'h00, typed_st, typed_alen, 1'b1));
      else due_items.push_back(make_item(KIND_STAT, 8'h00, st, trk_acct, 1'b1));
      clear_track();
    end
  endtask

  // Hold one word on the input until it is taken, then predict its results
  task automatic send_word(input logic [7:0] sym, input logic fin, input logic typed,
                           input status_e typed_st, input logic [4:0] typed_alen);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    symbol_i     <= sym;
    final_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_symbol(sym, fin, typed, typed_st, typed_alen);
    sent_words++;
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_items.size() != 0) @(posedge clk_i);
  endtask

  // Build one random track: mostly well formed, some noise, some damaged
  task automatic build_track();
    int pick;
    int n;
    trk_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) trk_bytes.push_back(rand_byte());
    end else begin
      if ($urandom_range(0, 1) == 1) trk_bytes.push_back(CH_COLON);
      pick = $urandom_range(0, 9);
      if (pick < 8) n = $urandom_range(12, 19);
      else if (pick == 8) n = $urandom_range(0, 11);
      else n = $urandom_range(20, 24);
      repeat (n) trk_bytes.push_back(rand_digit());
      case ($urandom_range(0, 5))
        0:       trk_bytes.push_back(CH_D);
        1:       trk_bytes.push_back(CH_APOS);
        2:       trk_bytes.push_back(CH_GT);
        default: trk_bytes.push_back(CH_EQ);
      endcase
      repeat (7) trk_bytes.push_back(rand_digit());
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(0, 3);
      else if (pick < 85) n = $urandom_range(20, 40);
      else n = 0;
      repeat (n) trk_bytes.push_back(rand_digit());
      if ($urandom_range(0, 9) < 7) begin
        trk_bytes.push_back(CH_END);
        repeat ($urandom_range(0, 3)) trk_bytes.push_back(rand_byte());
      end
      if ($urandom_range(0, 99) < 15)
        trk_bytes[$urandom_range(0, trk_bytes.size() - 1)] = rand_byte();
      if ($urandom_range(0, 99) < 10) begin
        n = $urandom_range(1, trk_bytes.size());
        while (trk_bytes.size() > n) void'(trk_bytes.pop_back());
      end
    end
  endtask

  // Stimulus
  initial begin
    dir_plan = '{
      // colon dropped, '>' separator, trailing digit not emitted
      '{CH_COLON, 1'b0, 1'b0, ST_OK, 5'd0},
      '{"5", 1'b0, 1'b0, ST_OK, 5'd0},
      '{CH_GT, 1'b0, 1'b0, ST_OK, 5'd0},
      '{"1", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"2", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"3", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"4", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"5", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"6", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"7", 1'b0, 1'b0, ST_OK, 5'd0},
      '{"0", 1'b1, 1'b1, ST_OK, 5'd1},
      // zero byte, 'D' separator, apostrophe in the expiry
      '{8'h00, 1'b0, 1'b0, ST_OK, 5'd0},
      '{CH_D, 1'b0, 1'b0, ST_OK, 5'd0},
      '{CH_APOS, 1'b1, 1'b1, ST_BAD_CHAR, 5'd1},
      // end sentinel first
      '{CH_END, 1'b1, 1'b1, ST_SHORT, 5'd0},
      // all-ones byte, then sentinel, then ignored digit
      '{8'hFF, 1'b0, 1'b0, ST_OK, 5'd0},
      '{CH_END, 1'b0, 1'b0, ST_OK, 5'd0},
      '{"1", 1'b1, 1'b1, ST_BAD_CHAR, 5'd1},
      // separator with nothing after it
      '{"4", 1'b0, 1'b0, ST_OK, 5'd0},
      '{CH_EQ, 1'b1, 1'b1, ST_SHORT, 5'd1},
      // lone colon
      '{CH_COLON, 1'b1, 1'b1, ST_SHORT, 5'd0}
    };
    clear_track();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan
    for (int i = 0; i < DIR_N; i++)
      send_word(dir_plan[i].sym, dir_plan[i].fin, dir_plan[i].typed, dir_plan[i].st,
                dir_plan[i].alen);
    drain();

    // Random tracks
    sent_words = 0;
    while (sent_words < RAND_WORDS) begin
      build_track();
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < trk_bytes.size(); i++)
        send_word(trk_bytes[i], i == trk_bytes.size() - 1, 1'b0, ST_OK, 5'd0);
      if ($urandom_range(0, 19) == 0) drain();
    end

    // Wait out the tail
    drain();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stall the output side in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_items.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d value %0d", $time,
                 kind_o, value_o);
        err_cnt++;
      end else begin
        want = due_items.pop_front();
        check_field("kind", int'(want.kind), int'(kind_o));
        check_field("value", int'(want.value), int'(value_o));
        check_field("status", int'(want.status), int'(status_o));
        check_field("account_length", int'(want.acct_len), int'(account_length_o));
        check_field("last_result", int'(want.last), int'(last_result_o));
      end
    end
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/t2fp_pkg.sv
hdl/t2fp_core.sv
hdl/t2fp_outq.sv
hdl/track2_field_parser.sv
dv/track2_field_parser_test.sv
